>>> design/c_subset_tokenizer_assert.svh
// Assertion macros used by the tokenizer's queue module.
`ifndef C_SUBSET_TOKENIZER_ASSERT_SVH
`define C_SUBSET_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS

`define CST_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

`define CST_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`else

`define CST_ASSERT_IMPLY(name, clk, rst_n, ante, cons)

`define CST_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> design/cst_pkg.sv
`timescale 1ns / 1ps

package cst_pkg;

  localparam int LINE_BITS   = 16;
  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);
  localparam int PREFIX_CHARS = 5;
  localparam int PREFIX_BITS  = 8 * PREFIX_CHARS;

  localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  // keyword text packed with the first character in the low byte
  localparam logic [PREFIX_BITS-1:0] KW_INT   = 40'h0000746E69;
  localparam logic [PREFIX_BITS-1:0] KW_CHAR  = 40'h0072616863;
  localparam logic [PREFIX_BITS-1:0] KW_IF    = 40'h0000006669;
  localparam logic [PREFIX_BITS-1:0] KW_ELSE  = 40'h0065736C65;
  localparam logic [PREFIX_BITS-1:0] KW_WHILE = 40'h656C696877;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM, M_Q1, M_Q2, M_REL, M_SLASH, M_LCOM, M_BCOM, M_BSTAR
  } mode_t;

  typedef enum logic [4:0] {
    K_ID, K_NUM, K_INT, K_CHAR, K_IF, K_ELSE, K_WHILE, K_PLUS, K_MINUS, K_MULT, K_DIV,
    K_ASSIGN, K_SEMI, K_CLIT, K_LP, K_RP, K_LB, K_RB, K_REL, K_END, K_ERR
  } kind_t;

  typedef enum logic [2:0] {
    R_NONE, R_LT, R_GT, R_LE, R_GE, R_EQ, R_NE, R_BANG
  } rel_t;

  typedef enum logic [1:0] {
    P_ASSIGN, P_BANG, P_LT, P_GT
  } pend_t;

  typedef struct packed {
    kind_t                  kind;
    rel_t                   rel;
    logic [LINE_BITS-1:0]   line;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
  } tok_t;

  typedef struct packed {
    logic v0;
    logic v1;
    tok_t tok0;
    tok_t tok1;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic kind_t kw_kind(input logic [PREFIX_BITS-1:0] p,
                                    input logic [LENGTH_BITS-1:0] n);
    kind_t k;
    k = K_ID;
    if (n == LENGTH_BITS'(3) && p == KW_INT) k = K_INT;
    if (n == LENGTH_BITS'(4) && p == KW_CHAR) k = K_CHAR;
    if (n == LENGTH_BITS'(2) && p == KW_IF) k = K_IF;
    if (n == LENGTH_BITS'(4) && p == KW_ELSE) k = K_ELSE;
    if (n == LENGTH_BITS'(5) && p == KW_WHILE) k = K_WHILE;
    return k;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_PLUS:  k = K_PLUS;
      CH_MINUS: k = K_MINUS;
      CH_STAR:  k = K_MULT;
      CH_SEMI:  k = K_SEMI;
      CH_LPAR:  k = K_LP;
      CH_RPAR:  k = K_RP;
      CH_LBRC:  k = K_LB;
      CH_RBRC:  k = K_RB;
      default:  k = K_ERR;
    endcase
    return k;
  endfunction

  function automatic kind_t op_kind(input pend_t p);
    return (p == P_ASSIGN) ? K_ASSIGN : K_REL;
  endfunction

  function automatic rel_t op_rel(input pend_t p);
    rel_t r;
    unique case (p)
      P_ASSIGN: r = R_NONE;
      P_BANG:   r = R_BANG;
      P_LT:     r = R_LT;
      P_GT:     r = R_GT;
      default:  r = R_NONE;
    endcase
    return r;
  endfunction

  function automatic rel_t pair_rel(input pend_t p);
    rel_t r;
    unique case (p)
      P_ASSIGN: r = R_EQ;
      P_BANG:   r = R_NE;
      P_LT:     r = R_LE;
      P_GT:     r = R_GE;
      default:  r = R_EQ;
    endcase
    return r;
  endfunction

endpackage

>>> design/cst_in_if.sv
`timescale 1ns / 1ps

interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

>>> design/cst_out_if.sv
`timescale 1ns / 1ps

interface cst_out_if;
  logic                            valid;
  logic                            ready;
  logic [4:0]                      token_kind;
  logic [2:0]                      relation_code;
  logic [cst_pkg::LINE_BITS-1:0]   token_line;
  logic [cst_pkg::OFFSET_BITS-1:0] start_offset;
  logic [cst_pkg::LENGTH_BITS-1:0] lexeme_length;
  logic                            last_of_run;

  modport source (output valid, output token_kind, output relation_code,
                  output token_line, output start_offset, output lexeme_length,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input relation_code,
                input token_line, input start_offset, input lexeme_length,
                input last_of_run, output ready);
endinterface

>>> design/cst_scan.sv
`timescale 1ns / 1ps

module cst_scan import cst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cst_in_if.sink    in_chan,
  input  logic      full,
  output logic      push,
  output bundle_t   push_data
);

  mode_t                   mode_r, mode_nxt;
  logic [LINE_BITS-1:0]    line_r, line_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0]  start_r, start_nxt;
  logic [LENGTH_BITS-1:0]  len_r, len_nxt;
  logic [PREFIX_BITS-1:0]  prefix_r, prefix_nxt;
  pend_t                   pend_r, pend_nxt;

  logic [7:0]             c;
  logic                   accept, eoi;
  logic                   c_alpha, c_digit, c_space, c_word, c_nl, c_quote;
  logic                   c_relch, c_slash, c_star, c_eq;
  logic                   rescan, idle_emits;
  logic [LINE_BITS-1:0]   line_inc;
  logic [LENGTH_BITS-1:0] len_inc;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [PREFIX_BITS-1:0] prefix_add;
  pend_t                  pend_of_c;
  tok_t                   tok_a, tok_b;
  logic                   va, vb;

  assign c       = in_chan.in_byte;
  assign accept  = in_chan.valid & in_chan.ready;
  assign eoi     = in_chan.end_of_input;
  assign in_chan.ready = ~full;

  assign c_alpha = is_alpha(c);
  assign c_digit = is_digit(c);
  assign c_space = is_space(c);
  assign c_word  = c_alpha | c_digit | (c == CH_UNDER);
  assign c_nl    = (c == CH_NL);
  assign c_quote = (c == CH_QUOTE);
  assign c_eq    = (c == CH_EQ);
  assign c_slash = (c == CH_SLASH);
  assign c_star  = (c == CH_STAR);
  assign c_relch = c_eq | (c == CH_BANG) | (c == CH_LT) | (c == CH_GT);

  assign line_inc = (line_r != LINE_MAX) ? line_r + 1'b1 : line_r;
  assign len_inc  = (len_r != LENGTH_MAX) ? len_r + 1'b1 : len_r;
  assign pos_inc  = (pos_r != OFFSET_MAX) ? pos_r + 1'b1 : pos_r;

  assign rescan = (mode_r == M_IDLE) ||
                  (mode_r == M_IDENT && !c_word) ||
                  (mode_r == M_NUM && !c_digit) ||
                  (mode_r == M_Q2 && !c_quote) ||
                  (mode_r == M_REL && !c_eq) ||
                  (mode_r == M_SLASH && !c_slash && !c_star);

  assign idle_emits = !c_space && !c_alpha && !c_digit && !c_quote && !c_relch && !c_slash;

  always_comb begin
    unique case (c)
      CH_EQ:   pend_of_c = P_ASSIGN;
      CH_BANG: pend_of_c = P_BANG;
      CH_LT:   pend_of_c = P_LT;
      default: pend_of_c = P_GT;
    endcase
  end

  always_comb begin
    prefix_add = prefix_r;
    for (int i = 0; i < PREFIX_CHARS; i++) begin
      if (len_r == LENGTH_BITS'(i)) prefix_add[8*i +: 8] = c;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    prefix_nxt = prefix_r;
    pend_nxt   = pend_r;
    if (accept) begin
      if (eoi) begin
        mode_nxt   = M_IDLE;
        line_nxt   = LINE_BITS'(1);
        pos_nxt    = '0;
        start_nxt  = '0;
        len_nxt    = '0;
        prefix_nxt = '0;
        pend_nxt   = P_ASSIGN;
      end else begin
        pos_nxt = pos_inc;
        unique case (mode_r)
          M_IDENT: if (c_word) begin
            prefix_nxt = prefix_add;
            len_nxt    = len_inc;
          end
          M_NUM: if (c_digit) len_nxt = len_inc;
          M_Q1: begin
            len_nxt  = LENGTH_BITS'(2);
            mode_nxt = M_Q2;
          end
          M_Q2: if (c_quote) mode_nxt = M_IDLE;
          M_REL: if (c_eq) mode_nxt = M_IDLE;
          M_SLASH: begin
            if (c_slash) mode_nxt = M_LCOM;
            else if (c_star) mode_nxt = M_BCOM;
          end
          M_LCOM: if (c_nl) begin
            line_nxt = line_inc;
            mode_nxt = M_IDLE;
          end
          M_BCOM: begin
            if (c_star) mode_nxt = M_BSTAR;
            else if (c_nl) line_nxt = line_inc;
          end
          M_BSTAR: begin
            if (c_slash) mode_nxt = M_IDLE;
            else if (!c_star) begin
              if (c_nl) line_nxt = line_inc;
              mode_nxt = M_BCOM;
            end
          end
          default: ;
        endcase
        if (rescan) begin
          mode_nxt   = M_IDLE;
          start_nxt  = pos_r;
          len_nxt    = LENGTH_BITS'(1);
          prefix_nxt = '0;
          if (c_space) begin
            if (c_nl) line_nxt = line_inc;
          end else if (c_alpha) begin
            mode_nxt   = M_IDENT;
            prefix_nxt = PREFIX_BITS'(c);
          end else if (c_digit) begin
            mode_nxt = M_NUM;
          end else if (c_quote) begin
            mode_nxt = M_Q1;
          end else if (c_relch) begin
            mode_nxt = M_REL;
            pend_nxt = pend_of_c;
          end else if (c_slash) begin
            mode_nxt = M_SLASH;
          end
        end
      end
    end
  end

  always_comb begin
    va    = 1'b0;
    vb    = 1'b0;
    tok_a = '{kind: K_ERR, rel: R_NONE, line: line_r, start: start_r, len: len_r};
    tok_b = '{kind: single_kind(c), rel: R_NONE, line: line_r, start: pos_r,
              len: LENGTH_BITS'(1)};
    if (eoi) begin
      unique case (mode_r)
        M_IDENT: begin
          va         = 1'b1;
          tok_a.kind = kw_kind(prefix_r, len_r);
        end
        M_NUM: begin
          va         = 1'b1;
          tok_a.kind = K_NUM;
        end
        M_Q1: begin
          va        = 1'b1;
          tok_a.len = LENGTH_BITS'(1);
        end
        M_Q2: begin
          va        = 1'b1;
          tok_a.len = LENGTH_BITS'(2);
        end
        M_REL: begin
          va         = 1'b1;
          tok_a.kind = op_kind(pend_r);
          tok_a.rel  = op_rel(pend_r);
          tok_a.len  = LENGTH_BITS'(1);
        end
        M_SLASH: begin
          va         = 1'b1;
          tok_a.kind = K_DIV;
          tok_a.len  = LENGTH_BITS'(1);
        end
        default: ;
      endcase
      vb         = 1'b1;
      tok_b.kind = K_END;
      tok_b.len  = '0;
      tok_b.line = (mode_r == M_LCOM) ? line_inc : line_r;
    end else begin
      unique case (mode_r)
        M_IDENT: if (!c_word) begin
          va         = 1'b1;
          tok_a.kind = kw_kind(prefix_r, len_r);
        end
        M_NUM: if (!c_digit) begin
          va         = 1'b1;
          tok_a.kind = K_NUM;
        end
        M_Q2: begin
          va = 1'b1;
          if (c_quote) begin
            tok_a.kind = K_CLIT;
            tok_a.len  = LENGTH_BITS'(3);
          end else begin
            tok_a.len = LENGTH_BITS'(2);
          end
        end
        M_REL: begin
          va         = 1'b1;
          tok_a.kind = c_eq ? K_REL : op_kind(pend_r);
          tok_a.rel  = c_eq ? pair_rel(pend_r) : op_rel(pend_r);
          tok_a.len  = c_eq ? LENGTH_BITS'(2) : LENGTH_BITS'(1);
        end
        M_SLASH: if (!c_slash && !c_star) begin
          va         = 1'b1;
          tok_a.kind = K_DIV;
          tok_a.len  = LENGTH_BITS'(1);
        end
        default: ;
      endcase
      vb = rescan & idle_emits;
    end
  end

  assign push           = accept & (va | vb);
  assign push_data.v0   = va;
  assign push_data.v1   = vb;
  assign push_data.tok0 = tok_a;
  assign push_data.tok1 = tok_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      line_r   <= LINE_BITS'(1);
      pos_r    <= '0;
      start_r  <= '0;
      len_r    <= '0;
      prefix_r <= '0;
      pend_r   <= P_ASSIGN;
    end else begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      prefix_r <= prefix_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

>>> design/cst_queue.sv
`timescale 1ns / 1ps
`include "c_subset_tokenizer_assert.svh"

module cst_queue import cst_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output bundle_t pop_data,
  output logic    empty
);

  bundle_t             mem_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                push_ok, pop_ok;

  assign full     = (cnt_r == CNT_BITS'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign push_ok  = push & ~full;
  assign pop_ok   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok && !pop_ok) cnt_nxt = cnt_r + 1'b1;
    else if (pop_ok && !push_ok) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `CST_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_BITS'(FIFO_DEPTH))
  `CST_ASSERT_NEXT(a_push_grows, clk, rst_n, push_ok && !pop_ok, cnt_r == $past(cnt_r) + 1'b1)
  `CST_ASSERT_NEXT(a_held_data, clk, rst_n, !empty && !pop_ok, !empty)
  `CST_ASSERT_IMPLY(a_ptr_gap, clk, rst_n, cnt_r != CNT_BITS'(FIFO_DEPTH) && cnt_r != '0, wr_ptr_r != rd_ptr_r)

endmodule

>>> design/cst_emit.sv
`timescale 1ns / 1ps

module cst_emit import cst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  output logic     pop,
  input  bundle_t  pop_data,
  input  logic     empty,
  cst_out_if.source out_chan
);

  bundle_t cur_r, cur_nxt;
  logic    v0_r, v0_nxt;
  logic    v1_r, v1_nxt;
  tok_t    shown;
  logic    xfer, last, done;

  assign shown = v0_r ? cur_r.tok0 : cur_r.tok1;
  assign last  = ~(v0_r & v1_r);
  assign xfer  = out_chan.valid & out_chan.ready;
  assign done  = ~(v0_r | v1_r) | (xfer & last);
  assign pop   = done & ~empty;

  assign out_chan.valid         = v0_r | v1_r;
  assign out_chan.token_kind    = 5'(shown.kind);
  assign out_chan.relation_code = 3'(shown.rel);
  assign out_chan.token_line    = shown.line;
  assign out_chan.start_offset  = shown.start;
  assign out_chan.lexeme_length = shown.len;
  assign out_chan.last_of_run   = last;

  always_comb begin
    cur_nxt = cur_r;
    v0_nxt  = v0_r;
    v1_nxt  = v1_r;
    if (pop) begin
      cur_nxt = pop_data;
      v0_nxt  = pop_data.v0;
      v1_nxt  = pop_data.v1;
    end else if (done) begin
      v0_nxt = 1'b0;
      v1_nxt = 1'b0;
    end else if (xfer) begin
      v0_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

endmodule

>>> design/c_subset_tokenizer.sv
// Streaming tokenizer for a small C subset.
// in_chan carries one source byte per transfer; a transfer with end_of_input
// set closes the text, flushes any open token and adds an end token.
// out_chan carries one token per transfer: kind, relation code, line,
// start offset and length; last_of_run marks the final token of a byte.
// Each input byte gives zero, one or two tokens.
// Throughput: one byte per cycle while the token queue has room; the output
// side moves one token per cycle while the receiver is ready, so a byte that
// yields two tokens holds the output for both and the queue absorbs the gap.
// A token that a byte completes is written into the queue, then loaded into
// the output stage before it is offered.
// A stalled receiver holds the current token; once the four-entry queue
// fills, in_chan.ready drops until room frees up.
// Reset (synchronous, active low) returns to line 1, offset 0 and clears
// the queue and the output stage. After an end token the scanner state is
// back at its reset values, so the next byte starts a fresh text.
`timescale 1ns / 1ps

module c_subset_tokenizer import cst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cst_in_if.sink    in_chan,
  cst_out_if.source out_chan
);

  logic    push, full, pop, empty;
  bundle_t push_data, pop_data;

  cst_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  cst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  cst_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty),
    .out_chan (out_chan)
  );

endmodule
